// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that carry checks.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle property violated");

`endif

// ----- rtl/ist_pkg.sv -----
// Shared types and constants for the integer set table.
// No dependencies; imported by every module of the block.
package ist_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 7;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new operation from the input channel
    logic lookup;  // compare every cell against the captured value
    logic exec;    // commit the table update and load the result register
  } dp_cmd_t;

endpackage

// ----- rtl/ist_datapath.sv -----
// Datapath of the integer set table: the row of entry cells, the count,
// the match vector and the result register. Depends on ist_pkg.
module ist_datapath #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ist_pkg::dp_cmd_t             cmd,
  input  ist_pkg::op_t                 in_mode,
  input  logic [ist_pkg::VALUE_W-1:0]  in_value,
  output logic                         res_success,
  output logic                         res_table_full,
  output logic [ist_pkg::COUNT_OUT_W-1:0] res_element_count,
  output logic                         res_set_empty
);
  import ist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] entries_r [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;
  op_t                mode_r;
  logic [VALUE_W-1:0] value_r;
  logic [CAPACITY-1:0] match_r;
  logic [CAPACITY-1:0] shift_mask;
  logic               found;
  logic               is_full;
  logic               do_add, do_remove;
  logic               success_nxt, full_nxt;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  logic                   success_r, table_full_r, set_empty_r;
  logic [COUNT_OUT_W-1:0] element_count_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
  end

  // Each cell compares its own entry; cells at or above the count never match.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      always_ff @(posedge clk) begin
        if (cmd.lookup) begin
          match_r[g] <= (CW'(g) < count_r) && (entries_r[g] == value_r);
        end
      end
      // Values are distinct, so at most one bit of match_r is set and every
      // cell at or above it takes its upper neighbor on a remove.
      assign shift_mask[g] = |match_r[g:0];
    end
  endgenerate

  assign found   = |match_r;
  assign is_full = (count_r == CW'(CAPACITY));

  always_comb begin
    count_nxt   = count_r;
    success_nxt = 1'b0;
    full_nxt    = 1'b0;
    do_add      = 1'b0;
    do_remove   = 1'b0;
    unique case (mode_r)
      OP_ADD: begin
        if (!found) begin
          if (is_full) begin
            full_nxt = 1'b1;
          end else begin
            do_add      = 1'b1;
            success_nxt = 1'b1;
            count_nxt   = count_r + CW'(1);
          end
        end
      end
      OP_REMOVE: begin
        if (found) begin
          do_remove   = 1'b1;
          success_nxt = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      OP_CONTAINS: begin
        success_nxt = found;
      end
      OP_CLEAR: begin
        success_nxt = 1'b1;
        count_nxt   = '0;
      end
      default: begin
        success_nxt = 1'b0;
      end
    endcase
  end

  generate
    for (g = 0; g < CAPACITY; g++) begin : g_store
      always_ff @(posedge clk) begin
        if (cmd.exec) begin
          if (do_add && (CW'(g) == count_r)) begin
            entries_r[g] <= value_r;
          end else if (do_remove && shift_mask[g]) begin
            if (g + 1 < CAPACITY) begin
              entries_r[g] <= entries_r[(g + 1) % CAPACITY];
            end
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      success_r       <= success_nxt;
      table_full_r    <= full_nxt;
      element_count_r <= count_ext[COUNT_OUT_W-1:0];
      set_empty_r     <= (count_nxt == '0);
    end
  end

  assign res_success       = success_r;
  assign res_table_full    = table_full_r;
  assign res_element_count = element_count_r;
  assign res_set_empty     = set_empty_r;

endmodule

// ----- rtl/ist_ctrl.sv -----
// Controller of the integer set table: sequences lookup and commit for each
// transaction and owns both handshakes. Depends on ist_pkg.
module ist_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output ist_pkg::dp_cmd_t cmd
);
  import ist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_EXEC   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can be loaded when empty or being emptied now.
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = S_LOOKUP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/integer_set_table.sv -----
// Integer set table: a set of distinct 32-bit values in insertion order.
// Each input transaction carries one operation: add, remove, contains or
// clear. Every transaction yields exactly one result transaction with a
// success flag, a table-full flag, the element count and an empty flag.
// Input tdata: mode in bits 1:0, value in bits 33:2. Output tdata: success,
// table_full, element_count (7 bits), set_empty from bit 0 up.
// Each accepted operation passes a lookup step (all cells compare in parallel
// into a registered match vector) and then a commit step (append, or a
// one-step shift of the cells above a hit) that loads the result register;
// the next operation can be accepted in the commit step of the last one.
// The result register parts the two sides: while a result waits, the next
// operation is accepted and looked up, and it holds in its commit step
// until the waiting result is taken. No result is dropped or repeated.
// Reset (rst_n low, synchronous) empties the set and clears the output valid;
// the entry cells are not cleared, as only cells below the count are read.
`include "assert_macros.svh"
module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode [1:0], value [33:2], zero pad [39:34]
  input  logic [ist_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // success [0], table_full [1], element_count [8:2], set_empty [9], pad [15:10]
  output logic [ist_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ist_pkg::*;

  dp_cmd_t                cmd;
  logic                   res_success, res_table_full, res_set_empty;
  logic [COUNT_OUT_W-1:0] res_element_count;

  ist_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ist_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (op_t'(in_tdata[1:0])),
    .in_value          (in_tdata[VALUE_W+1:2]),
    .res_success       (res_success),
    .res_table_full    (res_table_full),
    .res_element_count (res_element_count),
    .res_set_empty     (res_set_empty)
  );

  assign out_tdata = {{(OUT_TDATA_W - COUNT_OUT_W - 3){1'b0}}, res_set_empty,
                      res_element_count, res_table_full, res_success};

  `ASSERT_NEXT(a_accept_then_lookup, clk, rst_n, in_tvalid && in_tready, cmd.lookup)
  `ASSERT_NEXT(a_exec_loads_result, clk, rst_n, cmd.exec, out_tvalid)
  `ASSERT_ALWAYS(a_full_not_success, clk, rst_n, !(out_tvalid && res_success && res_table_full))
  `ASSERT_ALWAYS(a_lookup_not_exec, clk, rst_n, !(cmd.lookup && (cmd.exec || cmd.load)))

endmodule

// ----- tb/tb_integer_set_table.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for integer_set_table: streams add, remove, contains
// and clear transactions, predicts each reply from its own copy of the set.
// Depends on ist_pkg and the integer_set_table RTL.
module tb_integer_set_table;
  import ist_pkg::*;

  localparam int SET_CAP        = CAPACITY_DEF;
  localparam int POOL_N         = 100;
  localparam int RANDOM_ITEMS   = 520;
  localparam int LONG_STALL_AT  = 110;
  localparam int LONG_STALL     = 400;
  localparam int CYCLE_LIMIT    = 200000;

  // Field order mirrors out_tdata[9:0], highest bit first.
  typedef struct packed {
    logic       set_empty;
    logic [6:0] element_count;
    logic       table_full;
    logic       success;
  } set_result_t;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    set_result_t res;
  } set_reply_t;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    int unsigned gap;
    bit          drain;
  } set_op_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  set_op_item_t pending_ops[$];
  set_reply_t   awaited_replies[$];
  logic [31:0]  held_vals[$];
  logic [31:0]  value_pool[POOL_N];

  set_op_item_t cur_op;
  int unsigned  tx_wait;
  bit           tx_fire;
  int unsigned  accepted_cnt = 0;
  int unsigned  results_seen = 0;
  int unsigned  rx_wait;
  int unsigned  rx_draw;
  int unsigned  err_count = 0;
  int unsigned  cycle_cnt;

  integer_set_table #(.CAPACITY(SET_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one operation to the predicted set and returns its reply.
  function automatic set_result_t apply_set_op(op_t op, logic [31:0] v);
    set_result_t r;
    int          slot;
    r = '0;
    slot = -1;
    foreach (held_vals[i]) begin
      if (slot < 0 && held_vals[i] == v) slot = i;
    end
    case (op)
      OP_ADD: begin
        if (slot < 0) begin
          if (held_vals.size() >= SET_CAP) begin
            r.table_full = 1'b1;
          end else begin
            held_vals.push_back(v);
            r.success = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          held_vals.delete(slot);
          r.success = 1'b1;
        end
      end
      OP_CONTAINS: begin
        r.success = (slot >= 0);
      end
      default: begin
        held_vals.delete();
        r.success = 1'b1;
      end
    endcase
    r.element_count = 7'(held_vals.size());
    r.set_empty = (held_vals.size() == 0);
    return r;
  endfunction

  // Items 100 to 229 go back to back so the sender keeps pushing through the
  // long receiver stall; elsewhere about a third of the items have no gap.
  function automatic void queue_op(op_t op, logic [31:0] v, bit drain = 1'b0);
    set_op_item_t it;
    it.op = op;
    it.value = v;
    it.drain = drain;
    if (pending_ops.size() >= 100 && pending_ops.size() < 230) begin
      it.gap = 0;
    end else if ($urandom_range(0, 9) < 3) begin
      it.gap = 0;
    end else begin
      it.gap = $urandom_range(0, 19);
    end
    pending_ops.push_back(it);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic void fill_episode();
    int          start;
    int unsigned r;
    start = $urandom_range(0, POOL_N - 1);
    queue_op(OP_CLEAR, $urandom, 1'b1);
    for (int k = 0; k < 80; k++) begin
      queue_op(OP_ADD, value_pool[(start + k) % POOL_N]);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        queue_op(OP_CONTAINS, pick_value());
      end else if (r < 18) begin
        queue_op(OP_REMOVE, value_pool[(start + $urandom_range(0, k)) % POOL_N]);
      end
    end
    // The table is full here: present values and fresh ones both bounce.
    for (int k = 0; k < 12; k++) begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        queue_op(OP_ADD, value_pool[(start + $urandom_range(0, 79)) % POOL_N]);
      end else if (r == 1) begin
        queue_op(OP_ADD, $urandom);
      end else begin
        queue_op(OP_CONTAINS, pick_value());
      end
    end
  endfunction

  function automatic void mixed_episode();
    int          len;
    int unsigned r;
    len = $urandom_range(20, 60);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_op(OP_ADD, pick_value());
      end else if (r < 70) begin
        queue_op(OP_REMOVE, pick_value());
      end else if (r < 97) begin
        queue_op(OP_CONTAINS, pick_value());
      end else begin
        queue_op(OP_CLEAR, $urandom);
      end
    end
  endfunction

  // Driver: presents pending items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      tx_wait = 0;
      accepted_cnt <= 0;
    end else begin
      tx_fire = in_tvalid && in_tready;
      if (tx_fire) begin
        awaited_replies.push_back('{cur_op.op, cur_op.value,
                                    apply_set_op(cur_op.op, cur_op.value)});
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_tvalid && !tx_fire) begin
        // Hold the transaction until the block takes it.
      end else if (tx_wait > 0) begin
        tx_wait = tx_wait - 1;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0 &&
                   !(pending_ops[0].drain && (tx_fire || accepted_cnt != results_seen))) begin
        cur_op = pending_ops.pop_front();
        in_tdata <= {6'b0, cur_op.value, cur_op.op};
        in_tvalid <= 1'b1;
        tx_wait = (pending_ops.size() > 0) ? pending_ops[0].gap : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each reply against the oldest prediction and paces ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
      results_seen <= 0;
    end else if (out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply 0x%0h arrived with none outstanding", $time, out_tdata[9:0]);
        err_count++;
      end else if (set_result_t'(out_tdata[9:0]) !== awaited_replies[0].res) begin
        // Each group reads success/table_full/element_count/set_empty.
        $display("%0t: %s 0x%08h: expected %0b/%0b/%0d/%0b, got %0b/%0b/%0d/%0b",
                 $time, awaited_replies[0].op.name(), awaited_replies[0].value,
                 awaited_replies[0].res.success, awaited_replies[0].res.table_full,
                 awaited_replies[0].res.element_count, awaited_replies[0].res.set_empty,
                 out_tdata[0], out_tdata[1], out_tdata[8:2], out_tdata[9]);
        err_count++;
      end
      if (awaited_replies.size() > 0) void'(awaited_replies.pop_front());
      results_seen <= results_seen + 1;
      if (results_seen + 1 == LONG_STALL_AT) begin
        rx_draw = LONG_STALL;
      end else if ((results_seen >= 350 && results_seen < 450) ||
                   $urandom_range(0, 9) < 3) begin
        rx_draw = 0;
      end else begin
        rx_draw = $urandom_range(0, 19);
      end
      out_tready <= (rx_draw == 0);
      rx_wait <= rx_draw;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int produced;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    // Single-bit neighbors of one pattern catch a compare that misses a bit.
    for (int k = 5; k < 37; k++) value_pool[k] = 32'h5A5A_5A5A ^ (32'h1 << (k - 5));
    for (int k = 37; k < POOL_N; k++) value_pool[k] = $urandom;

    // Directed: empty-set cases, extremes, duplicates, removal with shift.
    queue_op(OP_CONTAINS, 32'h0000_0005);
    queue_op(OP_REMOVE, 32'h0000_0005);
    queue_op(OP_CLEAR, 32'h0000_0000);
    queue_op(OP_ADD, 32'h8000_0000);
    queue_op(OP_ADD, 32'h7FFF_FFFF);
    queue_op(OP_ADD, 32'h0000_0000);
    queue_op(OP_ADD, 32'hFFFF_FFFF);
    queue_op(OP_ADD, 32'h7FFF_FFFF);
    queue_op(OP_CONTAINS, 32'h8000_0000);
    queue_op(OP_CONTAINS, 32'h8000_0001);
    queue_op(OP_CONTAINS, 32'hFFFF_FFFF);
    queue_op(OP_REMOVE, 32'h7FFF_FFFF);
    queue_op(OP_CONTAINS, 32'h0000_0000);
    queue_op(OP_REMOVE, 32'h8000_0000);
    queue_op(OP_REMOVE, 32'hFFFF_FFFF);
    queue_op(OP_REMOVE, 32'hFFFF_FFFF);
    queue_op(OP_ADD, 32'hAAAA_AAAA);
    queue_op(OP_ADD, 32'h5555_5555);
    queue_op(OP_CONTAINS, 32'h5555_5555);
    queue_op(OP_CLEAR, 32'hFFFF_FFFF);
    queue_op(OP_CONTAINS, 32'h0000_0000);
    queue_op(OP_ADD, 32'h0000_0000);
    queue_op(OP_CLEAR, 32'h1234_5678);

    produced = pending_ops.size();
    fill_episode();
    while (pending_ops.size() - produced < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        fill_episode();
      end else if ($urandom_range(0, 99) < 15) begin
        for (int k = 0; k < 10; k++) queue_op(op_t'($urandom_range(0, 3)), $urandom);
      end else begin
        mixed_episode();
      end
    end
    // The sender waits here until every outstanding reply is back.
    queue_op(OP_CONTAINS, pick_value(), 1'b1);
    mixed_episode();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || in_tvalid || accepted_cnt != results_seen) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, awaited_replies.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- integer_set_table.f -----
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_datapath.sv
rtl/ist_ctrl.sv
rtl/integer_set_table.sv
tb/tb_integer_set_table.sv
